[design/lrub_pkg.sv]
// ----------------------------------------------------------------------------
// LRU block replacement package
// Shared sizes, command codes and the control bundle for the recency cells.
// ----------------------------------------------------------------------------
package lrub_pkg;

    // Number of cache blocks tracked by the policy.
    localparam int NUM_BLOCKS = 16;

    // Fixed field widths of the stream items.
    localparam int CMD_W   = 2;
    localparam int BLOCK_W = 4;

    // Width needed to name any block, and the width kept in each cell.
    localparam int IDX_W   = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int ENTRY_W = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_READ       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPLACE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 2'd3;

    // Control broadcast to every cell of the recency chain.
    typedef struct packed {
        logic               clear;   // empty the whole order
        logic               touch;   // look for key and move it to the tail
        logic               append;  // put tail into the first empty cell
        logic [ENTRY_W-1:0] key;     // block compared by a touch
        logic [ENTRY_W-1:0] tail;    // value written at the most-recent end
    } cell_ctrl_t;

endpackage

[design/lrub_cell.sv]
// ----------------------------------------------------------------------------
// LRU recency cell
// Holds one position of the recency order. Cells form a chain from least
// recent to most recent; a shift request ripples towards the recent end.
// ----------------------------------------------------------------------------
module lrub_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lrub_pkg::cell_ctrl_t          ctrl,
    input  logic                          shift_in,     // an older cell is leaving
    input  logic                          left_occ,     // older neighbour occupied
    input  logic                          right_occ,    // newer neighbour occupied
    input  logic [lrub_pkg::ENTRY_W-1:0]  right_entry,  // newer neighbour's block
    output logic                          shift_out,
    output logic                          occ,
    output logic [lrub_pkg::ENTRY_W-1:0]  entry
);
    import lrub_pkg::*;

    logic               occ_reg;
    logic               occ_next;
    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;
    logic               hit;

    // This cell holds the touched block, so it and all newer cells close up.
    assign hit       = ctrl.touch & occ_reg & (entry_reg == ctrl.key);
    assign shift_out = shift_in | hit;

    // Next contents: clear, close the gap, or take an appended block.
    always_comb begin
        occ_next   = occ_reg;
        entry_next = entry_reg;
        if (ctrl.clear) begin
            occ_next = 1'b0;
        end else if (shift_out && occ_reg) begin
            entry_next = right_occ ? right_entry : ctrl.tail;
        end else if (ctrl.append && !occ_reg && left_occ) begin
            occ_next   = 1'b1;
            entry_next = ctrl.tail;
        end
    end

    // Occupancy is control state; the block index is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign occ   = occ_reg;
    assign entry = entry_reg;

endmodule

[design/lrub_free_pick.sv]
// ----------------------------------------------------------------------------
// LRU free block picker
// Finds the lowest-numbered invalid block from the per-block valid flags.
// ----------------------------------------------------------------------------
module lrub_free_pick (
    input  logic [lrub_pkg::NUM_BLOCKS-1:0] valid_flags,
    output logic                            any_free,
    output logic [lrub_pkg::ENTRY_W-1:0]    free_idx,
    output logic [lrub_pkg::NUM_BLOCKS-1:0] free_onehot
);
    import lrub_pkg::*;

    // Lowest invalid block wins: scan from the top so the lowest one is last.
    always_comb begin
        free_idx = '0;
        for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
            if (!valid_flags[i]) begin
                free_idx = ENTRY_W'(i);
            end
        end
    end

    // One-hot form isolates the lowest clear bit.
    assign free_onehot = ~valid_flags & (valid_flags + NUM_BLOCKS'(1));
    assign any_free    = ~&valid_flags;

endmodule

[design/lru_block_replacement.sv]
// ----------------------------------------------------------------------------
// LRU block replacement policy
// Keeps the recency order of the cache blocks in a chain of cells and a
// valid flag per block; answers replace requests with a block index.
// ----------------------------------------------------------------------------
// A replace result is registered and shows on the master side in the cycle
// after the item is taken. Throughput: one item per cycle unless a held result
// stalls s_tready; the chain of cells applies a whole access, append or eviction.
// Reset: the order is empty and every block is invalid; no result is held.
// The stored block indices carry no reset and are read only once written.
module lru_block_replacement (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] block_index, [7:4] zero
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [3:0] victim_block, [7:4] zero
    output logic [0:0] m_tuser    // [0] was_free
);
    import lrub_pkg::*;

    logic                  accept;
    logic [CMD_W-1:0]      command;
    logic [BLOCK_W-1:0]    block_index;
    logic                  is_access;
    logic                  is_replace;
    logic                  is_invalidate;
    logic                  evict;
    cell_ctrl_t            ctrl;

    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [NUM_BLOCKS-1:0] valid_next;
    logic                  any_free;
    logic [ENTRY_W-1:0]    free_idx;
    logic [NUM_BLOCKS-1:0] free_onehot;

    logic [NUM_BLOCKS:0]   shift;
    logic [NUM_BLOCKS-1:0] occ;
    logic [ENTRY_W-1:0]    entry [NUM_BLOCKS];

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [BLOCK_W-1:0]    victim_reg;
    logic [BLOCK_W-1:0]    victim_next;
    logic                  was_free_reg;
    logic                  was_free_next;

    // Input handshake: the output register frees up when it is taken.
    assign s_tready    = ~m_valid_reg | m_tready;
    assign accept      = s_tvalid & s_tready;
    assign command     = s_tuser;
    assign block_index = s_tdata[BLOCK_W-1:0];

    // Command decode.
    assign is_access     = (command == CMD_READ) || (command == CMD_WRITE);
    assign is_replace    = (command == CMD_REPLACE);
    assign is_invalidate = (command == CMD_INVALIDATE);
    assign evict         = accept & is_replace & ~any_free;

    // Lowest free block.
    lrub_free_pick u_free_pick (
        .valid_flags (valid_reg),
        .any_free    (any_free),
        .free_idx    (free_idx),
        .free_onehot (free_onehot)
    );

    // Control for the cell chain. An eviction is a shift from the oldest cell
    // with the oldest block written back at the recent end.
    always_comb begin
        ctrl.clear  = accept & is_invalidate;
        ctrl.touch  = accept & is_access;
        ctrl.append = accept & is_replace & any_free;
        ctrl.key    = ENTRY_W'(block_index);
        if (is_replace && any_free) begin
            ctrl.tail = free_idx;
        end else if (is_replace) begin
            ctrl.tail = entry[0];
        end else begin
            ctrl.tail = ENTRY_W'(block_index);
        end
    end

    assign shift[0] = evict;

    // Recency chain, least recent in cell 0.
    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        logic               left_occ;
        logic               right_occ;
        logic [ENTRY_W-1:0] right_entry;

        if (g == 0) begin : g_first
            assign left_occ = 1'b1;
        end else begin : g_mid
            assign left_occ = occ[g-1];
        end

        if (g == NUM_BLOCKS - 1) begin : g_last
            assign right_occ   = 1'b0;
            assign right_entry = '0;
        end else begin : g_inner
            assign right_occ   = occ[g+1];
            assign right_entry = entry[g+1];
        end

        lrub_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .shift_in    (shift[g]),
            .left_occ    (left_occ),
            .right_occ   (right_occ),
            .right_entry (right_entry),
            .shift_out   (shift[g+1]),
            .occ         (occ[g]),
            .entry       (entry[g])
        );
    end

    // Valid flags: cleared by invalidate, set by a free-block replace.
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clear) begin
            valid_next = '0;
        end else if (ctrl.append) begin
            valid_next = valid_reg | free_onehot;
        end
    end

    // Result register for replace requests.
    always_comb begin
        m_valid_next  = m_valid_reg & ~m_tready;
        victim_next   = victim_reg;
        was_free_next = was_free_reg;
        if (accept && is_replace) begin
            m_valid_next  = 1'b1;
            was_free_next = any_free;
            if (any_free) begin
                victim_next = free_idx[BLOCK_W-1:0];
            end else if (occ[0]) begin
                victim_next = entry[0][BLOCK_W-1:0];
            end else begin
                victim_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        victim_reg   <= victim_next;
        was_free_reg <= was_free_next;
    end

    // Output packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - BLOCK_W){1'b0}}, victim_reg};
    assign m_tuser  = was_free_reg;

endmodule

[bench/lru_block_replacement_tb.sv]
// ----------------------------------------------------------------------------
// LRU block replacement testbench
// Sends read, write, replace and invalidate items into the policy and
// predicts every replace answer from its own copy of the recency order and
// valid flags, checking each answer field by field. Both stream sides idle at
// random; the sender drains all replies before the random part and some reads.
// ----------------------------------------------------------------------------
module lru_block_replacement_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lrub_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 625;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // One item waiting to be sent, with the idle cycles that go before it.
    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [BLOCK_W-1:0] blk;
        int                 pre_gap;
        bit                 drain;
    } access_req_t;

    // One predicted replace answer.
    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic               was_free;
    } victim_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [3:0] block_index, [7:4] zero
    logic [1:0] s_tuser;   // [1:0] command
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [3:0] victim_block, [7:4] zero
    logic [0:0] m_tuser;   // [0] was_free

    // Predicted policy state.
    logic [BLOCK_W-1:0] lru_chain [NUM_BLOCKS];
    int                 chain_len;
    bit                 blk_valid [NUM_BLOCKS];

    access_req_t pending_reqs[$];
    victim_t     victim_due[$];

    bit  gapless;
    bit  s_fire;
    bit  m_fire;
    int  gap_left;
    int  rx_wait;
    int  n_items;
    int  n_taken;
    int  n_free_seen;
    int  n_evict_seen;
    int  n_invalidates;
    int  n_mismatch;
    int  cycle_count;

    lru_block_replacement DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Move the entry at position pos to the most-recent end.
    function automatic void move_to_tail(input int pos);
        logic [BLOCK_W-1:0] moved;
        moved = lru_chain[pos];
        for (int i = pos; i + 1 < chain_len; i++) begin
            lru_chain[i] = lru_chain[i + 1];
        end
        lru_chain[chain_len - 1] = moved;
    endfunction

    // Apply one command to the predicted state; a replace yields an answer.
    function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                          input logic [BLOCK_W-1:0] blk,
                                          output bit has_victim,
                                          output victim_t answer);
        int free_idx;
        has_victim = 1'b0;
        answer     = '0;
        free_idx   = -1;
        case (cmd)
            CMD_READ, CMD_WRITE: begin
                // A block that is not in the order is left alone.
                for (int i = 0; i < chain_len; i++) begin
                    if (lru_chain[i] == blk) begin
                        move_to_tail(i);
                        break;
                    end
                end
            end
            CMD_INVALIDATE: begin
                chain_len = 0;
                foreach (blk_valid[i]) blk_valid[i] = 1'b0;
            end
            default: begin
                has_victim = 1'b1;
                for (int i = 0; i < NUM_BLOCKS; i++) begin
                    if (!blk_valid[i] && free_idx < 0) free_idx = i;
                end
                if (free_idx >= 0) begin
                    // The lowest invalid block is taken and joins the order.
                    blk_valid[free_idx] = 1'b1;
                    if (chain_len < NUM_BLOCKS) begin
                        lru_chain[chain_len] = free_idx[BLOCK_W-1:0];
                        chain_len++;
                    end
                    answer.block    = free_idx[BLOCK_W-1:0];
                    answer.was_free = 1'b1;
                end else if (chain_len > 0) begin
                    // Evict the least recent block and make it the most recent.
                    answer.block    = lru_chain[0];
                    answer.was_free = 1'b0;
                    move_to_tail(0);
                end
            end
        endcase
    endfunction

    // Add an item to the send queue with a gap drawn for it.
    task automatic queue_req(input logic [CMD_W-1:0] cmd, input int blk,
                             input bit drain);
        access_req_t req;
        req.cmd     = cmd;
        req.blk     = blk[BLOCK_W-1:0];
        req.pre_gap = gapless ? 0 : $urandom_range(0, 3);
        req.drain   = drain;
        pending_reqs.push_back(req);
        n_items++;
    endtask

    // Sender: inputs change on the falling edge.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire && pending_reqs.size() > 0) gap_left = pending_reqs[0].pre_gap;
            if (s_tvalid && !s_fire) begin
                // Item still waiting for the block; keep it steady.
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && victim_due.size() > 0)) begin
                s_tuser  <= pending_reqs[0].cmd;
                s_tdata  <= {4'b0000, pending_reqs[0].blk};
                s_tvalid <= 1'b1;
                void'(pending_reqs.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls a random number of cycles per answer, with quiet spells.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_fire) rx_wait = ((cycle_count / 500) % 3 == 0) ? 0 : $urandom_range(0, 3);
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Prediction on each accepted item, then checking of each accepted answer.
    always @(posedge aclk) begin
        bit      has_victim;
        victim_t answer;
        victim_t want;
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n_taken++;
                if (s_tuser == CMD_INVALIDATE) n_invalidates++;
                apply_command(s_tuser, s_tdata[BLOCK_W-1:0], has_victim, answer);
                if (has_victim) victim_due.push_back(answer);
            end
            if (m_tvalid && m_tready) begin
                if (victim_due.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("[%0t] unexpected answer: victim %0d free %0b",
                                 $realtime, m_tdata[BLOCK_W-1:0], m_tuser[0]);
                end else begin
                    want = victim_due.pop_front();
                    if (want.was_free) n_free_seen++;
                    else n_evict_seen++;
                    if (m_tdata[BLOCK_W-1:0] !== want.block || m_tuser[0] !== want.was_free) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display("[%0t] mismatch: victim %0d free %0b, expected %0d free %0b",
                                     $realtime, m_tdata[BLOCK_W-1:0], m_tuser[0],
                                     want.block, want.was_free);
                    end
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items taken",
                     cycle_count, n_taken, n_items);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int pick;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_READ;
        m_tready  = 1'b0;
        chain_len = 0;
        foreach (blk_valid[i]) blk_valid[i] = 1'b0;
        foreach (lru_chain[i]) lru_chain[i] = '0;

        // Directed part: accesses on an empty order, a full fill, reordering,
        // eviction of the least recent block and a refill after invalidate.
        gapless = 1'b0;
        queue_req(CMD_READ, 5, 1'b0);
        queue_req(CMD_WRITE, 15, 1'b0);
        for (int i = 0; i < NUM_BLOCKS; i++) queue_req(CMD_REPLACE, 0, 1'b0);
        queue_req(CMD_WRITE, 0, 1'b0);
        queue_req(CMD_READ, 15, 1'b0);
        queue_req(CMD_READ, 10, 1'b0);
        queue_req(CMD_REPLACE, 9, 1'b0);
        queue_req(CMD_REPLACE, 0, 1'b0);
        queue_req(CMD_INVALIDATE, 7, 1'b0);
        queue_req(CMD_REPLACE, 0, 1'b0);

        // Random part: mostly accesses and replaces, invalidate seldom so the
        // order fills up and evictions dominate; the first item waits for all
        // replies of the directed part.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gapless = ((n / 80) % 4 == 2);
            pick = $urandom_range(0, 199);
            if (pick < 3)
                queue_req(CMD_INVALIDATE, $urandom_range(0, 15), n == 0);
            else if (pick < 75)
                queue_req(CMD_REPLACE, $urandom_range(0, 15), n == 0);
            else if (pick < 137)
                queue_req(CMD_READ, $urandom_range(0, 15), n == 0 || n % 150 == 149);
            else
                queue_req(CMD_WRITE, $urandom_range(0, 15), n == 0);
        end

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        while (n_taken < n_items || victim_due.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (victim_due.size() > 0) begin
            n_mismatch++;
            $display("%0d answers never arrived", victim_due.size());
        end
        $display("sent %0d items including %0d invalidates; checked %0d free and %0d evicted",
                 n_taken, n_invalidates, n_free_seen, n_evict_seen);
        $display("answers, %0d mismatches over %0d cycles", n_mismatch, cycle_count);
        if (n_mismatch == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
